### src/csvfs_pkg.sv
// Types, codes and constants shared by the field splitter modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package csvfs_pkg;

  // Upper bound on fields that a delimiter may end
  localparam int unsigned CSVFS_MAX_FIELDS = 128;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_DELIMITER   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_QUOTE_CHAR  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ESCAPE_CHAR = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SKIP_SPACE  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_FIELD_LIMIT = 3'd4;

  // Result kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Characters
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_V     = 8'h76;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_TAB   = 8'h09;

  localparam int unsigned ResDepth = 3;

  typedef enum logic [4:0] {
    PH_START  = 5'b00001,
    PH_NORMAL = 5'b00010,
    PH_ESCAPE = 5'b00100,
    PH_QUOTE  = 5'b01000,
    PH_QEND   = 5'b10000
  } csvfs_phase_e;

  typedef enum logic {
    RET_NORMAL = 1'b0,
    RET_QUOTE  = 1'b1
  } csvfs_ret_e;

  typedef struct packed {
    logic [7:0] delimiter;
    logic [7:0] quote_char;
    logic [7:0] escape_char;
    logic       skip_space;
    logic [7:0] field_limit;
  } csvfs_cfg_t;

  typedef struct packed {
    csvfs_phase_e phase;
    csvfs_ret_e   ret;
    logic [7:0]   field_cnt;
    logic [15:0]  len_cnt;
  } csvfs_state_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  out_byte;
    logic [7:0]  field_number;
    logic [15:0] field_length;
    logic        record_done;
    logic        run_last;
  } csvfs_res_t;

  // Escape map: bit 8 set when the byte maps to a single data byte
  function automatic logic [8:0] unescape_map(input logic [7:0] ch);
    logic [8:0] r;
    case (ch)
      CH_N:      r = {1'b1, CH_LF};
      CH_R:      r = {1'b1, CH_CR};
      CH_V:      r = {1'b1, CH_VT};
      CH_F:      r = {1'b1, CH_FF};
      CH_T:      r = {1'b1, CH_TAB};
      CH_DQUOTE: r = {1'b1, ch};
      CH_APOS:   r = {1'b1, ch};
      CH_BSLASH: r = {1'b1, ch};
      default:   r = {1'b0, ch};
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### src/csvfs_step.sv
// Parse step for one record byte: next parser state and up to three results.
// Depends on csvfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module csvfs_step import csvfs_pkg::*; #(
  parameter int unsigned MAX_FIELDS = CSVFS_MAX_FIELDS
) (
  input  csvfs_cfg_t                 cfg_i,
  input  csvfs_state_t               state_i,
  input  logic [7:0]                 ch_i,
  input  logic                       eor_i,
  output csvfs_state_t               state_o,
  output csvfs_res_t [ResDepth-1:0]  res_o,
  output logic [1:0]                 res_cnt_o
);

  localparam logic [7:0] MaxFields = 8'(MAX_FIELDS);

  logic [7:0]   lim;
  logic         delim_hit;
  logic         esc_hit;
  logic         quote_open;
  logic [8:0]   umap;
  logic [1:0]   n_data;
  logic [7:0]   d0;
  logic [7:0]   d1;
  logic         delim_end;
  csvfs_phase_e phase_nx;
  csvfs_ret_e   ret_nx;
  logic [16:0]  len_sum;
  logic [15:0]  len_after;
  logic [7:0]   fc_after;
  logic [1:0]   k;

  // Byte classification against the configured characters
  always_comb begin
    lim        = (cfg_i.field_limit > MaxFields) ? MaxFields : cfg_i.field_limit;
    delim_hit  = (cfg_i.delimiter != 8'd0) && (ch_i == cfg_i.delimiter) &&
                 (state_i.field_cnt < lim);
    esc_hit    = (cfg_i.escape_char != 8'd0) && (ch_i == cfg_i.escape_char);
    quote_open = (cfg_i.quote_char != 8'd0) && (ch_i == cfg_i.quote_char);
    umap       = unescape_map(ch_i);
  end

  // Phase transitions and data bytes produced
  always_comb begin
    n_data    = 2'd0;
    d0        = ch_i;
    d1        = ch_i;
    delim_end = 1'b0;
    phase_nx  = state_i.phase;
    ret_nx    = state_i.ret;
    unique case (state_i.phase)
      PH_NORMAL: begin
        if (delim_hit) begin
          delim_end = 1'b1;
          phase_nx  = PH_START;
        end else if (esc_hit) begin
          phase_nx = PH_ESCAPE;
          ret_nx   = RET_NORMAL;
        end else begin
          n_data = 2'd1;
        end
      end
      PH_QUOTE: begin
        if (ch_i == cfg_i.quote_char) begin
          phase_nx = PH_QEND;
        end else if (esc_hit) begin
          phase_nx = PH_ESCAPE;
          ret_nx   = RET_QUOTE;
        end else begin
          n_data = 2'd1;
        end
      end
      PH_ESCAPE: begin
        if (umap[8]) begin
          n_data = 2'd1;
          d0     = umap[7:0];
        end else begin
          n_data = 2'd2;
          d0     = CH_BSLASH;
          d1     = ch_i;
        end
        phase_nx = (state_i.ret == RET_QUOTE) ? PH_QUOTE : PH_NORMAL;
      end
      PH_QEND: begin
        if (delim_hit) begin
          delim_end = 1'b1;
          phase_nx  = PH_START;
        end
      end
      default: begin
        if (delim_hit) begin
          delim_end = 1'b1;
          phase_nx  = PH_START;
        end else if (quote_open) begin
          phase_nx = PH_QUOTE;
        end else if (esc_hit) begin
          phase_nx = PH_ESCAPE;
          ret_nx   = RET_NORMAL;
        end else if (cfg_i.skip_space && (ch_i == CH_SPACE)) begin
          phase_nx = PH_START;
        end else begin
          n_data   = 2'd1;
          phase_nx = PH_NORMAL;
        end
      end
    endcase
  end

  // Counters: saturate length, saturate field index
  always_comb begin
    len_sum   = {1'b0, state_i.len_cnt} + 17'(n_data);
    len_after = len_sum[16] ? 16'hFFFF : len_sum[15:0];
    fc_after  = state_i.field_cnt;
    if (delim_end && (state_i.field_cnt != 8'hFF)) begin
      fc_after = state_i.field_cnt + 8'd1;
    end
  end

  // Pack results in order: data bytes, delimiter end, record end
  always_comb begin
    res_o = '0;
    k     = n_data;
    res_o[0].kind         = KIND_DATA;
    res_o[0].out_byte     = d0;
    res_o[0].field_number = state_i.field_cnt;
    res_o[1].kind         = KIND_DATA;
    res_o[1].out_byte     = d1;
    res_o[1].field_number = state_i.field_cnt;
    if (delim_end) begin
      res_o[k].kind         = KIND_END;
      res_o[k].out_byte     = 8'd0;
      res_o[k].field_number = state_i.field_cnt;
      res_o[k].field_length = len_after;
      res_o[k].record_done  = 1'b0;
      k = k + 2'd1;
    end
    if (eor_i) begin
      res_o[k].kind         = KIND_END;
      res_o[k].out_byte     = 8'd0;
      res_o[k].field_number = fc_after;
      res_o[k].field_length = delim_end ? 16'd0 : len_after;
      res_o[k].record_done  = 1'b1;
      k = k + 2'd1;
    end
    if (k != 2'd0) begin
      res_o[k - 2'd1].run_last = 1'b1;
    end
    res_cnt_o = k;
  end

  // Next state; record end returns everything to reset values
  always_comb begin
    if (eor_i) begin
      state_o.phase     = PH_START;
      state_o.ret       = RET_NORMAL;
      state_o.field_cnt = 8'd0;
      state_o.len_cnt   = 16'd0;
    end else begin
      state_o.phase     = phase_nx;
      state_o.ret       = ret_nx;
      state_o.field_cnt = fc_after;
      state_o.len_cnt   = delim_end ? 16'd0 : len_after;
    end
  end

endmodule

`default_nettype wire

### src/csv_field_splitter.sv
// Top level of the CSV field splitter: config registers, parser state, result buffer.
// Depends on csvfs_pkg and csvfs_step.
//
//   channel   direction  beat carries
//   s_axis    in         tdata: in_byte; tlast: end_of_record
//   m_axis    out        tdata: out_byte, field_number, field_length; tuser: kind,
//                        record_done; tlast: run_last
//   cfg       in         cfg_index_i: register index; cfg_data_i: value
//
// A byte is parsed in the cycle it is accepted and its 0 to 3 results are
// loaded into a three-entry result buffer, drained one beat per cycle while
// m_axis_tready_i is high. Throughput is one byte per cycle while each byte
// gives at most one result and the output is not stalled; a byte with more
// results holds the input until the single output port drains the buffer.
// Reset is asynchronous, active low, and clears config to its defaults and
// the parser to start of field. The config port is always ready.
`timescale 1ns / 1ps
`default_nettype none

module csv_field_splitter import csvfs_pkg::*; #(
  parameter int unsigned MAX_FIELDS = CSVFS_MAX_FIELDS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // tdata[7:0] in_byte
  input  logic [7:0]         s_axis_tdata_i,
  input  logic               s_axis_tlast_i,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  // tdata[7:0] out_byte, [15:8] field_number, [31:16] field_length
  output logic [31:0]        m_axis_tdata_o,
  // tuser[0] kind, [1] record_done
  output logic [1:0]         m_axis_tuser_o,
  output logic               m_axis_tlast_o,
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]         cfg_data_i
);

  csvfs_cfg_t                cfg_q;
  csvfs_state_t              state_q;
  csvfs_state_t              state_d;
  csvfs_res_t [ResDepth-1:0] step_res;
  logic [1:0]                step_cnt;
  csvfs_res_t [ResDepth-1:0] res_q;
  logic [1:0]                cnt_q;
  logic [1:0]                rd_q;
  csvfs_res_t                cur;
  logic                      in_beat;
  logic                      out_beat;
  logic                      out_last;

  assign cfg_ready_o = 1'b1;

  // Config register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delimiter   <= 8'd44;
      cfg_q.quote_char  <= 8'd34;
      cfg_q.escape_char <= 8'd1;
      cfg_q.skip_space  <= 1'b0;
      cfg_q.field_limit <= 8'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_DELIMITER:   cfg_q.delimiter   <= cfg_data_i;
        CFG_QUOTE_CHAR:  cfg_q.quote_char  <= cfg_data_i;
        CFG_ESCAPE_CHAR: cfg_q.escape_char <= cfg_data_i;
        CFG_SKIP_SPACE:  cfg_q.skip_space  <= cfg_data_i[0];
        CFG_FIELD_LIMIT: cfg_q.field_limit <= cfg_data_i;
        default: ;
      endcase
    end
  end

  csvfs_step #(
    .MAX_FIELDS(MAX_FIELDS)
  ) u_step (
    .cfg_i     (cfg_q),
    .state_i   (state_q),
    .ch_i      (s_axis_tdata_i),
    .eor_i     (s_axis_tlast_i),
    .state_o   (state_d),
    .res_o     (step_res),
    .res_cnt_o (step_cnt)
  );

  // Output side of the buffer
  assign cur             = res_q[rd_q];
  assign m_axis_tvalid_o = (cnt_q != 2'd0);
  assign m_axis_tdata_o  = {cur.field_length, cur.field_number, cur.out_byte};
  assign m_axis_tuser_o  = {cur.record_done, cur.kind};
  assign m_axis_tlast_o  = cur.run_last;

  assign out_beat = m_axis_tvalid_o && m_axis_tready_i;
  assign out_last = (rd_q == (cnt_q - 2'd1));

  // Take a new byte when the buffer is empty or drains its last entry now
  assign s_axis_tready_o = (cnt_q == 2'd0) || (out_beat && out_last);
  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;

  // Advance parser state on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase     <= PH_START;
      state_q.ret       <= RET_NORMAL;
      state_q.field_cnt <= 8'd0;
      state_q.len_cnt   <= 16'd0;
    end else if (in_beat) begin
      state_q <= state_d;
    end
  end

  // Buffer control: load on input beat, step read index on output beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      rd_q  <= 2'd0;
    end else if (in_beat) begin
      cnt_q <= step_cnt;
      rd_q  <= 2'd0;
    end else if (out_beat) begin
      if (out_last) begin
        cnt_q <= 2'd0;
        rd_q  <= 2'd0;
      end else begin
        rd_q <= rd_q + 2'd1;
      end
    end
  end

  // Hold result payload
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      res_q <= step_res;
    end
  end

  // Read index stays inside the loaded results
  a_rd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (rd_q < cnt_q))
    else $error("result read index beyond loaded count");

  // tlast marks exactly the final buffered result
  a_last_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tlast_o == out_last))
    else $error("run_last does not match final buffered result");

  // A byte with end of record leaves the parser at start of record
  a_eor_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && s_axis_tlast_i) |=>
      (state_q.phase == PH_START) && (state_q.field_cnt == 8'd0) &&
      (state_q.len_cnt == 16'd0))
    else $error("parser state not cleared after record end");

  // A record end always delivers a record_done result
  a_eor_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && s_axis_tlast_i) |=> (cnt_q != 2'd0) && res_q[cnt_q - 2'd1].record_done)
    else $error("record end gave no final field end");

endmodule

`default_nettype wire
